[rtl/core/qvrm_pkg.sv]
// Shared constants, payload types and the output rounding function.
package qvrm_pkg;

  localparam int FRAC_BITS = 30;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int ROOT_W    = FRAC_BITS + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int NUM_M     = 9;
  localparam int IN_W      = 3 * DATA_W;
  localparam int OUT_W     = NUM_M * DATA_W;

  localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yz;
    logic                     flag;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_t;

  // Round magnitude to nearest, ties away from zero, then saturate to 32 bits.
  // off selects the off-diagonal scaling (factor two folded into the shift).
  function automatic logic [DATA_W-1:0] round_sat(logic [SUM_W-1:0] mag, logic neg,
                                                  logic off);
    logic [SUM_W:0] rnd;
    logic [SUM_W:0] q;
    logic [DATA_W-1:0] res;
    rnd = {1'b0, mag} + (off ? ((SUM_W+1)'(1) << (FRAC_BITS - 2))
                             : ((SUM_W+1)'(1) << (FRAC_BITS - 1)));
    q = off ? (rnd >> (FRAC_BITS - 1)) : (rnd >> FRAC_BITS);
    if (!neg) begin
      res = (q > (SUM_W+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[DATA_W-1:0];
    end else begin
      res = (q > (SUM_W+1)'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                   : (~q[DATA_W-1:0]) + 32'd1;
    end
    return res;
  endfunction

endpackage

[rtl/core/qvrm_sqrt_step.sv]
// One registered step of the digit-by-digit square root, payload carried along.
module qvrm_sqrt_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  qvrm_pkg::root_t  in_root,
  input  qvrm_pkg::side_t  in_side,
  output logic             valid_r,
  output qvrm_pkg::root_t  root_r,
  output qvrm_pkg::side_t  side_r
);

  logic [qvrm_pkg::REM_W-1:0] rem_sh;
  logic [qvrm_pkg::REM_W-1:0] trial;
  logic                       ge;
  qvrm_pkg::root_t            root_nxt;

  always_comb begin
    rem_sh = {in_root.rem[qvrm_pkg::REM_W-3:0], in_root.rad[qvrm_pkg::RAD_W-1 -: 2]};
    trial  = qvrm_pkg::REM_W'({in_root.root, 2'b01});
    ge     = (rem_sh >= trial);
    root_nxt.rad  = in_root.rad << 2;
    root_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt.root = {in_root.root[qvrm_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

endmodule

[rtl/core/quaternion_vector_to_rotation_matrix.sv]
// Top level: unit quaternion vector part to 3x3 rotation matrix, Q2.30 pipeline.
//
// Input beat (in_*): x, y, z vector components of a unit quaternion, signed
// Q2.30. The scalar part w = floor(sqrt(1 - |v|^2)) is rebuilt in hardware.
// Output beat (out_*): the nine matrix entries in row-major order, Q2.30,
// rounded to nearest (ties away from zero) and saturated; out_tuser flags a
// squared norm above one, in which case w is taken as zero.
//
// Pipeline: 1 input stage, 1 multiply stage, 1 norm stage, FRAC_BITS+1 root
// steps (one result bit per stage), then multiply, sum, magnitude and round
// stages: 38 register stages at FRAC_BITS = 30.
// Throughput: one beat per cycle while the skid register is empty; every stage
// is registered and the whole pipe advances together.
// Stall: a one-entry skid register behind the last stage catches the beat
// that meets a low out_tready, so in_tready is a register output with no path
// from out_tready. While the skid is full the pipe holds, nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module quaternion_vector_to_rotation_matrix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [31:0] vec_x, [63:32] vec_y, [95:64] vec_z
  input  logic [qvrm_pkg::IN_W-1:0]    in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [31:0] m00, m01, m02, m10, m11, m12, m20, m21, [287:256] m22
  output logic [qvrm_pkg::OUT_W-1:0]   out_tdata,
  // [0] norm_overflow
  output logic                         out_tuser
);

  localparam int DW = qvrm_pkg::DATA_W;
  localparam int PW = qvrm_pkg::PROD_W;
  localparam int SW = qvrm_pkg::SUM_W;
  localparam int RW = qvrm_pkg::ROOT_W;
  localparam int NM = qvrm_pkg::NUM_M;

  // global advance: the pipe moves unless the skid holds a beat
  logic en;
  logic skid_v_r;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // ---- stage 0: input capture
  logic                 v0_r;
  logic signed [DW-1:0] x0_r, y0_r, z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_tdata[DW-1:0];
      y0_r <= in_tdata[2*DW-1:DW];
      z0_r <= in_tdata[3*DW-1:2*DW];
    end
  end

  // ---- stage 1: six products, exact 2F-fraction
  logic           v1_r;
  qvrm_pkg::side_t s1_r, s1_nxt;

  always_comb begin
    s1_nxt      = '0;
    s1_nxt.x    = x0_r;
    s1_nxt.y    = y0_r;
    s1_nxt.z    = z0_r;
    s1_nxt.xx   = x0_r * x0_r;
    s1_nxt.yy   = y0_r * y0_r;
    s1_nxt.zz   = z0_r * z0_r;
    s1_nxt.xy   = x0_r * y0_r;
    s1_nxt.xz   = x0_r * z0_r;
    s1_nxt.yz   = y0_r * z0_r;
    s1_nxt.flag = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // ---- stage 2: squared norm, overflow flag, radicand
  logic                           v2_r;
  qvrm_pkg::side_t                s2_r, s2_nxt;
  logic [qvrm_pkg::RAD_W-1:0]     rad2_r, rad2_nxt;
  logic [SW-1:0]                  nrm;
  logic [SW-1:0]                  rad_full;

  always_comb begin
    nrm      = SW'(s1_r.xx) + SW'(s1_r.yy) + SW'(s1_r.zz);
    s2_nxt   = s1_r;
    s2_nxt.flag = (nrm > qvrm_pkg::ONE);
    rad_full = s2_nxt.flag ? '0 : (qvrm_pkg::ONE - nrm);
    rad2_nxt = rad_full[qvrm_pkg::RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s2_nxt;
      rad2_r <= rad2_nxt;
    end
  end

  // ---- root pipeline: one result bit per stage
  logic            rv   [0:RW];
  qvrm_pkg::root_t rt   [0:RW];
  qvrm_pkg::side_t sd   [0:RW];

  assign rv[0]      = v2_r;
  assign rt[0].rad  = rad2_r;
  assign rt[0].rem  = '0;
  assign rt[0].root = '0;
  assign sd[0]      = s2_r;

  for (genvar g = 0; g < RW; g++) begin : g_root
    qvrm_sqrt_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (rv[g]),
      .in_root  (rt[g]),
      .in_side  (sd[g]),
      .valid_r  (rv[g+1]),
      .root_r   (rt[g+1]),
      .side_r   (sd[g+1])
    );
  end

  // ---- multiply stage: w terms
  logic                 vm_r;
  qvrm_pkg::side_t      sm_r;
  logic [2*RW-1:0]      ww_r;
  logic signed [PW:0]   wx_r, wy_r, wz_r;
  logic signed [RW:0]   w_s;

  assign w_s = {1'b0, rt[RW].root};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= rv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r <= sd[RW];
      ww_r <= rt[RW].root * rt[RW].root;
      wx_r <= (PW+1)'(w_s) * (PW+1)'(sd[RW].x);
      wy_r <= (PW+1)'(w_s) * (PW+1)'(sd[RW].y);
      wz_r <= (PW+1)'(w_s) * (PW+1)'(sd[RW].z);
    end
  end

  // ---- sum stage: nine exact entries, row-major
  logic                 va_r;
  logic                 fa_r;
  logic signed [SW-1:0] sum_r [NM];
  logic signed [SW-1:0] sum_nxt [NM];
  logic signed [SW-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;

  always_comb begin
    e_ww = SW'($signed({1'b0, ww_r}));
    e_xx = SW'(sm_r.xx);
    e_yy = SW'(sm_r.yy);
    e_zz = SW'(sm_r.zz);
    e_xy = SW'(sm_r.xy);
    e_xz = SW'(sm_r.xz);
    e_yz = SW'(sm_r.yz);
    e_wx = SW'(wx_r);
    e_wy = SW'(wy_r);
    e_wz = SW'(wz_r);
    sum_nxt[0] = e_ww + e_xx - e_yy - e_zz;
    sum_nxt[1] = e_xy - e_wz;
    sum_nxt[2] = e_xz + e_wy;
    sum_nxt[3] = e_xy + e_wz;
    sum_nxt[4] = e_ww + e_yy - e_xx - e_zz;
    sum_nxt[5] = e_yz - e_wx;
    sum_nxt[6] = e_xz - e_wy;
    sum_nxt[7] = e_yz + e_wx;
    sum_nxt[8] = e_ww + e_zz - e_xx - e_yy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r <= sm_r.flag;
      for (int i = 0; i < NM; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
    end
  end

  // ---- magnitude stage
  logic          vg_r;
  logic          fg_r;
  logic [SW-1:0] mag_r [NM];
  logic [NM-1:0] neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fg_r <= fa_r;
      for (int i = 0; i < NM; i++) begin
        neg_r[i] <= sum_r[i][SW-1];
        mag_r[i] <= sum_r[i][SW-1] ? SW'(-sum_r[i]) : SW'(sum_r[i]);
      end
    end
  end

  // ---- round and saturate stage (last pipe stage)
  logic                 vl_r;
  logic                 fl_r;
  logic [qvrm_pkg::OUT_W-1:0] dl_r, dl_nxt;

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      // diagonal entries sit at 0, 4 and 8
      dl_nxt[i*DW +: DW] = qvrm_pkg::round_sat(mag_r[i], neg_r[i],
                                               !(i == 0 || i == 4 || i == 8));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= 1'b0;
    end else if (en) begin
      vl_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r <= fg_r;
      dl_r <= dl_nxt;
    end
  end

  // ---- skid register: catches the beat that meets a stalled receiver
  logic                       skid_f_r;
  logic [qvrm_pkg::OUT_W-1:0] skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (vl_r && !out_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_d_r <= dl_r;
      skid_f_r <= fl_r;
    end
  end

  assign out_tvalid = skid_v_r || vl_r;
  assign out_tdata  = skid_v_r ? skid_d_r : dl_r;
  assign out_tuser  = skid_v_r ? skid_f_r : fl_r;

`ifndef SYNTHESIS
  // skid only fills from a valid last stage that was refused
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(vl_r && !out_tready))
    else $error("skid filled without a refused beat");

  // a drained skid is empty next cycle
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> !skid_v_r)
    else $error("skid did not drain");

  // overflowing norm gives a zero radicand, hence a zero root
  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rv[RW] && sd[RW].flag) |-> (rt[RW].root == '0))
    else $error("nonzero root with norm overflow");
`endif

endmodule

[tb/quaternion_vector_to_rotation_matrix_tb.sv]
// Testbench for the quaternion vector to rotation matrix pipeline.
`timescale 1ns / 100ps

module quaternion_vector_to_rotation_matrix_tb;

  // Expected output beat: nine entries and the overflow flag.
  typedef struct {
    logic [qvrm_pkg::DATA_W-1:0] m [qvrm_pkg::NUM_M];
    logic                        ovf;
  } rot_t;

  // Scoreboard: predicts the matrix for each accepted quaternion, checks beats.
  class rot_scoreboard;
    rot_t   pending[$];
    int     errors;
    int     n_checked;
    int     n_ovf;

    function new();
      errors = 0;
      n_checked = 0;
      n_ovf = 0;
    endfunction

    // Bitwise integer square root of a 64-bit radicand.
    function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Round to nearest (ties away), saturate to 32 bits.
    function automatic logic [qvrm_pkg::DATA_W-1:0] rnd_sat(logic signed [127:0] v, int sh);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (v < 0) ? -v : v;
      q = (mag + (128'd1 << (sh - 1))) >> sh;
      if (v >= 0) return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return -q[31:0];
    endfunction

    function void note_input(logic [qvrm_pkg::IN_W-1:0] d);
      logic signed [127:0] x, y, z, xx, yy, zz, w, ww;
      logic [127:0] nrm;
      logic [127:0] unit;
      rot_t e;
      x = $signed(d[31:0]);
      y = $signed(d[63:32]);
      z = $signed(d[95:64]);
      xx = x * x; yy = y * y; zz = z * z;
      nrm = xx + yy + zz;
      unit = 128'd1 << (2 * qvrm_pkg::FRAC_BITS);
      w = 0;
      e.ovf = nrm > unit;
      if (!e.ovf) w = isqrt(64'(unit - nrm));
      ww = w * w;
      e.m[0] = rnd_sat(ww + xx - yy - zz, qvrm_pkg::FRAC_BITS);
      e.m[4] = rnd_sat(ww + yy - xx - zz, qvrm_pkg::FRAC_BITS);
      e.m[8] = rnd_sat(ww + zz - xx - yy, qvrm_pkg::FRAC_BITS);
      e.m[1] = rnd_sat(x * y - w * z, qvrm_pkg::FRAC_BITS - 1);
      e.m[2] = rnd_sat(x * z + w * y, qvrm_pkg::FRAC_BITS - 1);
      e.m[3] = rnd_sat(x * y + w * z, qvrm_pkg::FRAC_BITS - 1);
      e.m[5] = rnd_sat(y * z - w * x, qvrm_pkg::FRAC_BITS - 1);
      e.m[6] = rnd_sat(x * z - w * y, qvrm_pkg::FRAC_BITS - 1);
      e.m[7] = rnd_sat(y * z + w * x, qvrm_pkg::FRAC_BITS - 1);
      pending.push_back(e);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch @%0t: %s", $realtime, what);
    endtask

    task check_result(logic [qvrm_pkg::OUT_W-1:0] d, logic u);
      rot_t e;
      if (pending.size() == 0) begin
        report("output beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.ovf) n_ovf++;
      for (int i = 0; i < qvrm_pkg::NUM_M; i++)
        if (d[i*qvrm_pkg::DATA_W +: qvrm_pkg::DATA_W] !== e.m[i])
          report($sformatf("m%0d%0d got %h want %h", i / 3, i % 3,
                           d[i*qvrm_pkg::DATA_W +: qvrm_pkg::DATA_W], e.m[i]));
      if (u !== e.ovf) report($sformatf("norm_overflow got %b want %b", u, e.ovf));
    endtask
  endclass

  localparam logic [31:0] P1 = 32'sh4000_0000;   // +1.0
  localparam logic [31:0] N1 = 32'shC000_0000;   // -1.0

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [qvrm_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [qvrm_pkg::OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic stim_done = 0;
  logic sink_busy = 1;   // sink stalls randomly while high
  int   n_sent = 0;

  rot_scoreboard sb = new();

  quaternion_vector_to_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial forever #4 clk = ~clk;

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one beat, hold until accepted; optional idle cycles first.
  task send_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z, int idle);
    repeat (idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input({z, y, x});
    n_sent++;
    @(negedge clk);
  endtask

  // Random component: any value (mode 0), within +-1.0 (mode 1) or within +-0.5 (otherwise).
  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      default: return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    endcase
  endfunction

  // Draw a random vector part: components of any value, within +-1.0, or within +-0.5.
  task send_random(int idle);
    logic [31:0] x, y, z;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      x = rand_comp(0); y = rand_comp(0); z = rand_comp(0);
    end else if (mode < 4) begin
      x = rand_comp(1); y = rand_comp(1); z = rand_comp(1);
    end else begin
      x = rand_comp(2); y = rand_comp(2); z = rand_comp(2);
    end
    send_beat(x, y, z, idle);
  endtask

  // Sink: random stalls, with stall-free stretches.
  always @(negedge clk) begin
    if (!sink_busy) out_tready <= 1;
    else out_tready <= (gap_len() == 0);
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: identity, axes, signs, norm exactly one, over one, extremes.
    send_beat(0, 0, 0, 0);
    send_beat(P1, 0, 0, 0);
    send_beat(0, N1, 0, 0);
    send_beat(0, 0, P1, 0);
    send_beat(N1, 0, 0, 0);
    send_beat(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000, 1);
    send_beat(32'sh2000_0000, 32'shE000_0000, 32'sh2000_0000, 0);
    send_beat(32'sh2000_0000, 32'sh2000_0000, 32'sh2000_0000 + 1, 0);  // z one LSB above 0.5
    send_beat(P1, P1, P1, 0);
    send_beat(N1, N1, N1, 0);
    send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2);
    send_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 0);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 0);
    send_beat(32'sh2D41_3CCD, 32'sh2D41_3CCD, 0, 0);  // about 1/sqrt2
    send_beat(1, 0, 0, 0);
    send_beat(32'sh3FFF_FFFF, 0, 0, 0);

    // Hold off until the pipe has drained completely.
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);

    for (int i = 0; i < 1600; i++) begin
      if (i == 600) sink_busy = 0;
      if (i == 800) sink_busy = 1;
      if (i >= 400 && i < 600) send_random(0);
      else send_random(gap_len());
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d quaternions, checked %0d matrices, %0d with norm overflow",
             n_sent, sb.n_checked, sb.n_ovf);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

endmodule
